/* src/tt_pkg.sv */
`default_nettype none
package tt_pkg;

	localparam int MAX_SOURCE_BYTES = 1048576;
	localparam int KEYWORD_CHARS    = 6;
	localparam int FIFO_DEPTH       = 4;

	localparam logic [2:0] SUB_BEGIN   = 3'd0;
	localparam logic [2:0] SUB_STRIP   = 3'd1;
	localparam logic [2:0] SUB_TEXT    = 3'd2;
	localparam logic [2:0] SUB_COMMENT = 3'd3;
	localparam logic [2:0] SUB_IDLE    = 3'd4;
	localparam logic [2:0] SUB_STRING  = 3'd5;
	localparam logic [2:0] SUB_NUMBER  = 3'd6;
	localparam logic [2:0] SUB_IDENT   = 3'd7;

	localparam logic [5:0] K_TEXT        = 6'd0;
	localparam logic [5:0] K_EXPR_BEGIN  = 6'd1;
	localparam logic [5:0] K_EXPR_END    = 6'd2;
	localparam logic [5:0] K_BLOCK_BEGIN = 6'd3;
	localparam logic [5:0] K_BLOCK_END   = 6'd4;
	localparam logic [5:0] K_STRING      = 6'd5;
	localparam logic [5:0] K_NUMBER      = 6'd6;
	localparam logic [5:0] K_IDENT       = 6'd7;
	localparam logic [5:0] K_FOR         = 6'd8;
	localparam logic [5:0] K_IN          = 6'd9;
	localparam logic [5:0] K_ENDFOR      = 6'd10;
	localparam logic [5:0] K_IF          = 6'd11;
	localparam logic [5:0] K_ELIF        = 6'd12;
	localparam logic [5:0] K_ELSE        = 6'd13;
	localparam logic [5:0] K_ENDIF       = 6'd14;
	localparam logic [5:0] K_SET         = 6'd15;
	localparam logic [5:0] K_AND         = 6'd16;
	localparam logic [5:0] K_OR          = 6'd17;
	localparam logic [5:0] K_NOT         = 6'd18;
	localparam logic [5:0] K_IS          = 6'd19;
	localparam logic [5:0] K_TRUE        = 6'd20;
	localparam logic [5:0] K_FALSE       = 6'd21;
	localparam logic [5:0] K_NONE        = 6'd22;
	localparam logic [5:0] K_OP_EQ       = 6'd23;
	localparam logic [5:0] K_OP_NE       = 6'd24;
	localparam logic [5:0] K_OP_LE       = 6'd25;
	localparam logic [5:0] K_OP_GE       = 6'd26;
	localparam logic [5:0] K_UNKNOWN     = 6'd46;
	localparam logic [5:0] K_END         = 6'd47;

	typedef struct packed {
		logic        in_tag;
		logic        strip;
		logic        esc;
		logic        quote;
		logic [2:0]  sub;
		logic [1:0]  skip;
		logic [20:0] pos;
		logic [20:0] line;
		logic [20:0] col;
		logic [20:0] tok_off;
		logic [20:0] tok_line;
		logic [20:0] tok_col;
		logic [20:0] lnp;
		logic [47:0] kw;
	} lex_state_t;

	localparam lex_state_t LEX_RESET = '{
		in_tag: 1'b0, strip: 1'b0, esc: 1'b0, quote: 1'b0, sub: SUB_BEGIN, skip: 2'd0,
		pos: 21'd0, line: 21'd1, col: 21'd1, tok_off: 21'd0, tok_line: 21'd0,
		tok_col: 21'd0, lnp: 21'd0, kw: 48'd0
	};

	typedef struct packed {
		logic [5:0]  token_kind;
		logic [19:0] start_offset;
		logic [20:0] token_length;
		logic [20:0] start_line;
		logic [20:0] start_column;
		logic        last_token;
	} token_t;

	typedef struct packed {
		logic   vld;
		token_t tok;
	} opt_tok_t;

	typedef struct packed {
		lex_state_t st;
		logic [1:0] n;
		token_t     t0;
		token_t     t1;
	} step_t;

	typedef struct packed {
		logic [1:0] n;
		token_t     t0;
		token_t     t1;
	} push_t;

	function automatic logic is_space(logic [7:0] c);
		return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic token_t make_tok(logic [5:0] k, logic [20:0] off, logic [20:0] len,
		logic [20:0] ln, logic [20:0] cl, logic last);
		token_t t;
		t.token_kind   = k;
		t.start_offset = off[19:0];
		t.token_length = len;
		t.start_line   = ln;
		t.start_column = cl;
		t.last_token   = last;
		return t;
	endfunction

	function automatic lex_state_t eat(lex_state_t s_in, logic [7:0] c);
		lex_state_t s;
		s = s_in;
		s.pos = s.pos + 21'd1;
		if (c == 8'h0A) begin
			if (s.line < 21'(MAX_SOURCE_BYTES)) s.line = s.line + 21'd1;
			s.col = 21'd1;
		end else if (s.col < 21'(MAX_SOURCE_BYTES)) begin
			s.col = s.col + 21'd1;
		end
		return s;
	endfunction

	function automatic logic [5:0] ident_kind(logic [20:0] len, logic [47:0] kw);
		logic [5:0] k;
		k = K_IDENT;
		case (len)
			21'd2: begin
				if (kw == 48'h696E) k = K_IN;
				else if (kw == 48'h6966) k = K_IF;
				else if (kw == 48'h6F72) k = K_OR;
				else if (kw == 48'h6973) k = K_IS;
			end
			21'd3: begin
				if (kw == 48'h666F72) k = K_FOR;
				else if (kw == 48'h736574) k = K_SET;
				else if (kw == 48'h616E64) k = K_AND;
				else if (kw == 48'h6E6F74) k = K_NOT;
			end
			21'd4: begin
				if (kw == 48'h656C6966) k = K_ELIF;
				else if (kw == 48'h656C7365) k = K_ELSE;
				else if (kw == 48'h74727565 || kw == 48'h54727565) k = K_TRUE;
				else if (kw == 48'h6E6F6E65 || kw == 48'h4E6F6E65) k = K_NONE;
				else if (kw == 48'h6E756C6C) k = K_NONE;
			end
			21'd5: begin
				if (kw == 48'h656E646966) k = K_ENDIF;
				else if (kw == 48'h66616C7365 || kw == 48'h46616C7365) k = K_FALSE;
			end
			21'd6: begin
				if (kw == 48'h656E64666F72) k = K_ENDFOR;
			end
			default: k = K_IDENT;
		endcase
		return k;
	endfunction

	function automatic logic [5:0] op_kind(logic [7:0] c);
		logic [5:0] k;
		case (c)
			8'h2E: k = 6'd27;
			8'h2C: k = 6'd28;
			8'h3A: k = 6'd29;
			8'h7C: k = 6'd30;
			8'h7E: k = 6'd31;
			8'h2B: k = 6'd32;
			8'h2D: k = 6'd33;
			8'h2A: k = 6'd34;
			8'h2F: k = 6'd35;
			8'h25: k = 6'd36;
			8'h3C: k = 6'd37;
			8'h3E: k = 6'd38;
			8'h3D: k = 6'd39;
			8'h28: k = 6'd40;
			8'h29: k = 6'd41;
			8'h5B: k = 6'd42;
			8'h5D: k = 6'd43;
			8'h7B: k = 6'd44;
			8'h7D: k = 6'd45;
			default: k = K_UNKNOWN;
		endcase
		return k;
	endfunction

	function automatic opt_tok_t pending_tok(lex_state_t s);
		opt_tok_t o;
		logic [20:0] len;
		len = s.pos - s.tok_off;
		o.vld = 1'b0;
		o.tok = make_tok(K_TEXT, s.tok_off, len, s.tok_line, s.tok_col, 1'b0);
		case (s.sub)
			SUB_TEXT: o.vld = (len != 21'd0);
			SUB_STRING: begin
				o.vld = 1'b1;
				o.tok.token_kind = K_STRING;
			end
			SUB_NUMBER: begin
				o.vld = 1'b1;
				o.tok.token_kind = K_NUMBER;
			end
			SUB_IDENT: begin
				o.vld = 1'b1;
				o.tok.token_kind = (len > 21'(KEYWORD_CHARS)) ? K_IDENT : ident_kind(len, s.kw);
			end
			default: o.vld = 1'b0;
		endcase
		return o;
	endfunction

	function automatic step_t lex_process(lex_state_t s_in, logic [7:0] c0, logic v1,
		logic [7:0] c1, logic v2, logic [7:0] c2);
		lex_state_t s;
		step_t      r;
		token_t     tk;
		opt_tok_t   pt;
		logic [1:0] n;
		logic       done;
		logic       trim;
		logic       close3;
		logic [5:0] k;
		logic [20:0] len;
		s = s_in;
		n = 2'd0;
		done = 1'b0;
		r.t0 = '0;
		r.t1 = '0;
		if (s.skip != 2'd0) begin
			s.skip = s.skip - 2'd1;
			s = eat(s, c0);
			done = 1'b1;
		end
		if (!done && s.sub == SUB_BEGIN) begin
			s.tok_off  = s.pos;
			s.tok_line = s.line;
			s.tok_col  = s.col;
			s.sub      = s.strip ? SUB_STRIP : SUB_TEXT;
			s.lnp      = s.pos;
		end
		if (!done && s.sub == SUB_STRIP) begin
			if (is_space(c0)) begin
				s = eat(s, c0);
				done = 1'b1;
			end else begin
				s.strip   = 1'b0;
				s.tok_off = s.pos;
				s.lnp     = s.pos;
				s.sub     = SUB_TEXT;
			end
		end
		if (!done && s.sub == SUB_NUMBER) begin
			if (is_digit(c0) || c0 == 8'h2E) begin
				s = eat(s, c0);
				done = 1'b1;
			end else begin
				pt = pending_tok(s);
				r.t0 = pt.tok;
				n = 2'd1;
				s.sub = SUB_IDLE;
			end
		end
		if (!done && s.sub == SUB_IDENT) begin
			if (is_alpha(c0) || is_digit(c0) || c0 == 8'h5F) begin
				if (s.pos - s.tok_off < 21'(KEYWORD_CHARS)) s.kw = {s.kw[39:0], c0};
				s = eat(s, c0);
				done = 1'b1;
			end else begin
				pt = pending_tok(s);
				r.t0 = pt.tok;
				n = 2'd1;
				s.sub = SUB_IDLE;
			end
		end
		if (!done && s.sub == SUB_TEXT) begin
			if (c0 == 8'h7B && v1 && (c1 == 8'h7B || c1 == 8'h25 || c1 == 8'h23)) begin
				trim = v2 && c2 == 8'h2D;
				len = (trim ? s.lnp : s.pos) - s.tok_off;
				if (len != 21'd0) begin
					r.t0 = make_tok(K_TEXT, s.tok_off, len, s.tok_line, s.tok_col, 1'b0);
					n = 2'd1;
				end
				s.skip = trim ? 2'd2 : 2'd1;
				if (c1 == 8'h23) begin
					s.sub = SUB_COMMENT;
				end else begin
					tk = make_tok((c1 == 8'h7B) ? K_EXPR_BEGIN : K_BLOCK_BEGIN, s.pos,
						trim ? 21'd3 : 21'd2, s.line, s.col, 1'b0);
					if (n == 2'd0) r.t0 = tk;
					else r.t1 = tk;
					n = n + 2'd1;
					s.in_tag = 1'b1;
					s.sub = SUB_IDLE;
				end
			end else if (!is_space(c0)) begin
				s.lnp = s.pos + 21'd1;
			end
			s = eat(s, c0);
			done = 1'b1;
		end
		if (!done && s.sub == SUB_COMMENT) begin
			if (c0 == 8'h2D && v1 && c1 == 8'h23 && v2 && c2 == 8'h7D) begin
				s.skip = 2'd2;
				s.strip = 1'b1;
				s.sub = SUB_BEGIN;
			end else if (c0 == 8'h23 && v1 && c1 == 8'h7D) begin
				s.skip = 2'd1;
				s.strip = 1'b0;
				s.sub = SUB_BEGIN;
			end
			s = eat(s, c0);
			done = 1'b1;
		end
		if (!done && s.sub == SUB_IDLE) begin
			if (!is_space(c0)) begin
				close3 = c0 == 8'h2D && v1 && v2 && c2 == 8'h7D;
				tk = make_tok(K_UNKNOWN, s.pos, 21'd1, s.line, s.col, 1'b0);
				if (close3 && (c1 == 8'h7D || c1 == 8'h25)) begin
					tk.token_kind = (c1 == 8'h7D) ? K_EXPR_END : K_BLOCK_END;
					tk.token_length = 21'd3;
					s.skip = 2'd2;
					s.in_tag = 1'b0;
					s.strip = 1'b1;
					s.sub = SUB_BEGIN;
				end else if ((c0 == 8'h7D || c0 == 8'h25) && v1 && c1 == 8'h7D) begin
					tk.token_kind = (c0 == 8'h7D) ? K_EXPR_END : K_BLOCK_END;
					tk.token_length = 21'd2;
					s.skip = 2'd1;
					s.in_tag = 1'b0;
					s.strip = 1'b0;
					s.sub = SUB_BEGIN;
				end else if (c0 == 8'h22 || c0 == 8'h27) begin
					s.tok_off = s.pos + 21'd1;
					s.tok_line = s.line;
					s.tok_col = s.col;
					s.sub = SUB_STRING;
					s.quote = (c0 == 8'h27);
					s.esc = 1'b0;
					tk.token_kind = K_END;
				end else if (is_digit(c0)) begin
					s.tok_off = s.pos;
					s.tok_line = s.line;
					s.tok_col = s.col;
					s.sub = SUB_NUMBER;
					tk.token_kind = K_END;
				end else if (is_alpha(c0) || c0 == 8'h5F) begin
					s.tok_off = s.pos;
					s.tok_line = s.line;
					s.tok_col = s.col;
					s.sub = SUB_IDENT;
					s.kw = {40'd0, c0};
					tk.token_kind = K_END;
				end else begin
					k = K_UNKNOWN;
					if (v1 && c1 == 8'h3D) begin
						if (c0 == 8'h3D) k = K_OP_EQ;
						else if (c0 == 8'h21) k = K_OP_NE;
						else if (c0 == 8'h3C) k = K_OP_LE;
						else if (c0 == 8'h3E) k = K_OP_GE;
					end
					if (k != K_UNKNOWN) begin
						tk.token_kind = k;
						tk.token_length = 21'd2;
						s.skip = 2'd1;
					end else begin
						tk.token_kind = op_kind(c0);
					end
				end
				if (tk.token_kind != K_END) begin
					if (n == 2'd0) r.t0 = tk;
					else r.t1 = tk;
					n = n + 2'd1;
				end
			end
			s = eat(s, c0);
			done = 1'b1;
		end
		if (!done && s.sub == SUB_STRING) begin
			if (s.esc) begin
				s.esc = 1'b0;
			end else if (c0 == 8'h5C) begin
				s.esc = 1'b1;
			end else if (c0 == (s.quote ? 8'h27 : 8'h22)) begin
				pt = pending_tok(s);
				r.t0 = pt.tok;
				n = 2'd1;
				s.sub = SUB_IDLE;
			end
			s = eat(s, c0);
		end
		r.st = s;
		r.n = n;
		return r;
	endfunction

endpackage
`default_nettype wire

/* src/tt_if.sv */
`default_nettype none
interface tt_src_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] char_value;
	modport source (output valid, kind, char_value, input ready);
	modport sink (input valid, kind, char_value, output ready);
endinterface

interface tt_tok_if;
	logic        valid;
	logic        ready;
	logic [5:0]  token_kind;
	logic [19:0] start_offset;
	logic [20:0] token_length;
	logic [20:0] start_line;
	logic [20:0] start_column;
	logic        last_token;
	modport source (output valid, token_kind, start_offset, token_length, start_line,
		start_column, last_token, input ready);
	modport sink (input valid, token_kind, start_offset, token_length, start_line,
		start_column, last_token, output ready);
endinterface
`default_nettype wire

/* src/template_tag_tokenizer.sv */
// a token enters the queue at the transfer of the second byte past the byte that
// decides it, and is offered in the next cycle at the earliest, from the queue head
// throughput: one source byte per cycle while the token queue has room and no flush runs;
// up to two tokens stored per cycle, one sent; end of source: input held off while the
// window drains and the end token is queued after the end marker transfer
// reset: asynchronous, active low; clears mode, window, counters and token queue
`default_nettype none
module template_tag_tokenizer (
	input wire logic clk,
	input wire logic arst_n,
	tt_src_if.sink   src,
	tt_tok_if.source tok
);
	import tt_pkg::*;

	push_t      push;
	logic [2:0] count;
	logic       room;

	assign room = count <= 3'd2;

	tt_lexer_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.room   (room),
		.src    (src),
		.push   (push)
	);

	tt_token_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.count  (count),
		.tok    (tok)
	);

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count <= 3'd4) else $error("token queue overflow");
	a_end_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(src.valid && src.ready && src.kind) |=> !src.ready) else $error("input taken in flush");
	a_last_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		(tok.valid && tok.last_token) |-> tok.token_kind == K_END) else $error("bad last token");
`endif

endmodule
`default_nettype wire

/* src/tt_lexer_core.sv */
`default_nettype none
module tt_lexer_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          room,
	tt_src_if.sink             src,
	output tt_pkg::push_t      push
);
	import tt_pkg::*;

	lex_state_t state_q;
	logic [7:0] w0_q, w1_q;
	logic [1:0] wc_q;
	logic       flush_q;
	logic [2:0] ecnt_q;

	logic       xfer, byte_x, end_x, over;
	logic [7:0] pc0, pc1, pc2;
	logic       pv1, pv2;
	step_t      r;
	opt_tok_t   ep;
	token_t     etok;
	push_t      raw;
	logic [1:0] allow;

	assign src.ready = !flush_q && room;
	assign xfer   = src.valid && src.ready;
	assign byte_x = xfer && !src.kind;
	assign end_x  = xfer && src.kind;
	assign over   = ({1'b0, state_q.pos} + {20'd0, wc_q}) >= 22'(MAX_SOURCE_BYTES);

	always_comb begin
		pc0 = w0_q;
		pv1 = 1'b1;
		pc1 = w1_q;
		pv2 = 1'b1;
		pc2 = src.char_value;
		if (flush_q) begin
			pv2 = 1'b0;
			pc2 = 8'd0;
			if (wc_q != 2'd2) begin
				pv1 = 1'b0;
				pc1 = 8'd0;
			end
		end
	end

	assign r  = lex_process(state_q, pc0, pv1, pc1, pv2, pc2);
	assign ep = pending_tok(state_q);
	assign etok = make_tok(K_END, state_q.pos, 21'd0, state_q.line, state_q.col, 1'b1);

	always_comb begin
		raw = '0;
		if (flush_q && room) begin
			if (wc_q != 2'd0) begin
				raw.n = r.n;
				raw.t0 = r.t0;
				raw.t1 = r.t1;
			end else if (ep.vld) begin
				raw.n = 2'd2;
				raw.t0 = ep.tok;
				raw.t1 = etok;
			end else begin
				raw.n = 2'd1;
				raw.t0 = etok;
			end
		end else if (byte_x && !over && wc_q == 2'd2) begin
			raw.n = r.n;
			raw.t0 = r.t0;
			raw.t1 = r.t1;
		end
		allow = raw.n;
		if (flush_q) begin
			if (ecnt_q >= 3'd4) allow = 2'd0;
			else if (ecnt_q == 3'd3 && raw.n != 2'd0) allow = 2'd1;
		end
		push = raw;
		push.n = allow;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LEX_RESET;
			wc_q    <= 2'd0;
			flush_q <= 1'b0;
			ecnt_q  <= 3'd0;
		end else if (flush_q) begin
			if (room) begin
				ecnt_q <= ecnt_q + {1'b0, allow};
				if (wc_q == 2'd0) begin
					state_q <= LEX_RESET;
					flush_q <= 1'b0;
				end else begin
					state_q <= r.st;
					wc_q <= wc_q - 2'd1;
				end
			end
		end else if (end_x) begin
			flush_q <= 1'b1;
			ecnt_q  <= 3'd0;
		end else if (byte_x && !over) begin
			if (wc_q == 2'd2) state_q <= r.st;
			else wc_q <= wc_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (flush_q) begin
			if (room && wc_q == 2'd2) w0_q <= w1_q;
		end else if (byte_x && !over) begin
			case (wc_q)
				2'd0: w0_q <= src.char_value;
				2'd1: w1_q <= src.char_value;
				default: begin
					w0_q <= w1_q;
					w1_q <= src.char_value;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* src/tt_token_fifo.sv */
`default_nettype none
module tt_token_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire tt_pkg::push_t push,
	output logic [2:0]         count,
	tt_tok_if.source           tok
);
	import tt_pkg::*;

	token_t     mem_q [FIFO_DEPTH];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       pop;
	token_t     head;

	assign head = mem_q[rp_q];
	assign pop  = tok.valid && tok.ready;
	assign count = cnt_q;

	assign tok.valid        = cnt_q != 3'd0;
	assign tok.token_kind   = head.token_kind;
	assign tok.start_offset = head.start_offset;
	assign tok.token_length = head.token_length;
	assign tok.start_line   = head.start_line;
	assign tok.start_column = head.start_column;
	assign tok.last_token   = head.last_token;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 2'd0;
			rp_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			wp_q  <= wp_q + push.n;
			rp_q  <= rp_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push.n} - {2'd0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) mem_q[wp_q] <= push.t0;
		if (push.n == 2'd2) mem_q[wp_q + 2'd1] <= push.t1;
	end

endmodule
`default_nettype wire
